// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; clocked on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define U8D_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/u8d_pkg.sv
// ---------------------------------------------------------------------------
// u8d_pkg
// Types and character constants shared by the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
package u8d_pkg;

  localparam int CP_W  = 31;
  localparam int LEN_W = 3;

  typedef logic [CP_W-1:0]  cp_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic space;
    logic line_break;
  } char_class_t;

  // line breaks
  localparam cp_t CP_LF  = 31'h0000_000A;
  localparam cp_t CP_VT  = 31'h0000_000B;
  localparam cp_t CP_FF  = 31'h0000_000C;
  localparam cp_t CP_CR  = 31'h0000_000D;
  localparam cp_t CP_NEL = 31'h0000_0085;
  localparam cp_t CP_LS  = 31'h0000_2028;
  localparam cp_t CP_PS  = 31'h0000_2029;

  // whitespace
  localparam cp_t CP_NUL        = 31'h0000_0000;
  localparam cp_t CP_TAB        = 31'h0000_0009;
  localparam cp_t CP_SPACE      = 31'h0000_0020;
  localparam cp_t CP_NBSP       = 31'h0000_00A0;
  localparam cp_t CP_OGHAM      = 31'h0000_1680;
  localparam cp_t CP_EN_QUAD    = 31'h0000_2000;
  localparam cp_t CP_HAIR_SPACE = 31'h0000_200A;
  localparam cp_t CP_NNBSP      = 31'h0000_202F;
  localparam cp_t CP_MMSP       = 31'h0000_205F;
  localparam cp_t CP_IDEO_SPACE = 31'h0000_3000;

endpackage

// File: hw/rtl/u8d_classify.sv
// ---------------------------------------------------------------------------
// u8d_classify
// Whitespace and line break classification of one code point.
// ---------------------------------------------------------------------------
module u8d_classify
  import u8d_pkg::*;
(
  input  cp_t         code_point,
  input  logic        newline_counts_as_space,
  output char_class_t cls
);

  logic lb;
  logic plain_space;

  assign lb = (code_point == CP_LF) || (code_point == CP_VT) ||
              (code_point == CP_FF) || (code_point == CP_CR) ||
              (code_point == CP_NEL) || (code_point == CP_LS) ||
              (code_point == CP_PS);

  assign plain_space = (code_point == CP_NUL) || (code_point == CP_TAB) ||
                       (code_point == CP_SPACE) || (code_point == CP_NBSP) ||
                       (code_point == CP_OGHAM) || (code_point == CP_NNBSP) ||
                       (code_point == CP_MMSP) || (code_point == CP_IDEO_SPACE) ||
                       ((code_point >= CP_EN_QUAD) && (code_point <= CP_HAIR_SPACE));

  assign cls.line_break = lb;
  assign cls.space      = plain_space || (lb && newline_counts_as_space);

endmodule

// File: hw/rtl/utf8_stream_decoder.sv
// ---------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with character classification.
// ---------------------------------------------------------------------------
// Takes one text byte per word on the slave stream and gives one decoded
// character per word on the master stream once its last byte has arrived
// (1 to 6 byte sequences). A byte is taken every cycle the output register
// is empty or being drained, so the sustained rate is one byte per clock;
// a character is output in the cycle after its last byte. Bytes following a
// start byte are treated as continuations regardless of their top bits.
// A stray continuation byte gives code point 0 with the stray flag set.
// ---------------------------------------------------------------------------
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_we,
  input  logic        cfg_wdata,      // newline_counts_as_space

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,        // text_byte

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,        // code_point[30:0], byte_length[33:31], zero fill
  output logic [2:0]  m_tuser         // space_flag, line_break_flag, stray_flag
);

  `include "assert_macros.svh"

  logic        nl_space;
  len_t        bytes_pending, bytes_pending_next;
  len_t        seq_len, seq_len_next;
  cp_t         acc, acc_next;

  logic        out_valid, out_valid_next;
  cp_t         out_cp;
  len_t        out_len;
  logic        out_space, out_lb, out_stray;

  logic        accept;
  logic        emit;
  cp_t         emit_cp;
  len_t        emit_len;
  logic        emit_stray;
  cp_t         acc_shift;
  len_t        start_extra;
  logic [4:0]  start_payload;
  char_class_t cls;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign acc_shift = {acc[CP_W-7:0], s_tdata[5:0]};

  always_comb begin
    unique case (s_tdata) inside
      8'b110?_????: begin start_extra = 3'd1; start_payload = s_tdata[4:0]; end
      8'b1110_????: begin start_extra = 3'd2; start_payload = {1'b0, s_tdata[3:0]}; end
      8'b1111_0???: begin start_extra = 3'd3; start_payload = {2'b0, s_tdata[2:0]}; end
      8'b1111_10??: begin start_extra = 3'd4; start_payload = {3'b0, s_tdata[1:0]}; end
      8'b1111_11??: begin start_extra = 3'd5; start_payload = {4'b0, s_tdata[0]}; end
      default:      begin start_extra = 3'd0; start_payload = 5'd0; end
    endcase
  end

  always_comb begin
    bytes_pending_next = bytes_pending;
    seq_len_next       = seq_len;
    acc_next           = acc;
    emit               = 1'b0;
    emit_cp            = '0;
    emit_len           = 3'd1;
    emit_stray         = 1'b0;
    if (accept) begin
      if (bytes_pending != 3'd0) begin
        bytes_pending_next = bytes_pending - 3'd1;
        if (bytes_pending == 3'd1) begin
          emit         = 1'b1;
          emit_cp      = acc_shift;
          emit_len     = seq_len;
          seq_len_next = 3'd0;
          acc_next     = '0;
        end else begin
          acc_next = acc_shift;
        end
      end else if (!s_tdata[7]) begin
        emit    = 1'b1;
        emit_cp = {23'd0, s_tdata};
      end else if (!s_tdata[6]) begin
        emit       = 1'b1;
        emit_stray = 1'b1;
      end else begin
        bytes_pending_next = start_extra;
        seq_len_next       = start_extra + 3'd1;
        acc_next           = {26'd0, start_payload};
      end
    end
  end

  u8d_classify u_classify (
    .code_point              (emit_cp),
    .newline_counts_as_space (nl_space),
    .cls                     (cls)
  );

  always_comb begin
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nl_space      <= 1'b1;
      bytes_pending <= '0;
      seq_len       <= '0;
      acc           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        nl_space <= cfg_wdata;
      end
      bytes_pending <= bytes_pending_next;
      seq_len       <= seq_len_next;
      acc           <= acc_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cp    <= emit_cp;
      out_len   <= emit_len;
      out_space <= cls.space;
      out_lb    <= cls.line_break;
      out_stray <= emit_stray;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_len, out_cp};
  assign m_tuser  = {out_stray, out_lb, out_space};

  `U8D_ASSERT(a_idle_no_len, bytes_pending == 3'd0, seq_len == 3'd0, "length left with nothing pending")
  `U8D_ASSERT(a_len_covers, bytes_pending != 3'd0, seq_len > bytes_pending, "length below pending count")
  `U8D_ASSERT(a_stray_word, m_tvalid && m_tuser[2], m_tdata[33:0] == 34'h0_8000_0000, "bad stray word")
  `U8D_ASSERT_NEXT(a_last_byte_out, accept && bytes_pending == 3'd1, m_tvalid && m_tdata[33:31] == $past(seq_len), "sequence end lost")

endmodule
